/* rtl/kcl_pkg.sv */
// Shared types and constants for the keypad combination lock.
// No dependencies; used by kcl_core and keypad_combination_lock_top.
package kcl_pkg;

  localparam logic [7:0] KeyHash  = 8'h23;
  localparam logic [7:0] KeyStar  = 8'h2A;
  localparam logic [7:0] KeyZero  = 8'h30;
  localparam logic [7:0] KeyNine  = 8'h39;
  localparam logic [7:0] KeyA     = 8'h41;
  localparam logic [7:0] KeyD     = 8'h44;
  localparam logic [7:0] KeyDigit1 = 8'h31;

  typedef enum logic [1:0] {
    RELOCK_START = 2'd0,
    RELOCK_WAIT  = 2'd1,
    RELOCK_FIRED = 2'd2
  } relock_e;

  // Result of one tick, as it leaves the core.
  typedef struct packed {
    logic       code_changed;
    logic [2:0] program_stage;
    logic [2:0] entry_progress;
    logic       unlocked;
  } result_t;

endpackage

/* rtl/kcl_core.sv */
// State and next-state logic of the keypad combination lock: entry, relock
// and programming machines plus the stored code. Depends on kcl_pkg.
module kcl_core #(
  parameter int FACTORY_CODE_LENGTH = 5,
  parameter int USER_CODE_LENGTH    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       key_char_i,
  input  logic             lock_button_i,
  output kcl_pkg::result_t result_o
);

  localparam int MaxLen      = (FACTORY_CODE_LENGTH > USER_CODE_LENGTH) ?
                               FACTORY_CODE_LENGTH : USER_CODE_LENGTH;
  localparam int OpenStage   = MaxLen + 1;
  localparam int CommitStage = USER_CODE_LENGTH + 1;
  localparam int StageRaw    = $clog2(OpenStage + 1);
  localparam int StageW      = (StageRaw > 3) ? StageRaw : 3;
  localparam int IdxW        = $clog2(MaxLen);
  localparam int PendIdxW    = (USER_CODE_LENGTH > 1) ? $clog2(USER_CODE_LENGTH) : 1;

  localparam logic [StageW-1:0] StageOne    = StageW'(1);
  localparam logic [StageW-1:0] StageOpen   = StageW'(OpenStage);
  localparam logic [StageW-1:0] StageCommit = StageW'(CommitStage);
  localparam logic [StageW-1:0] LenFactory  = StageW'(FACTORY_CODE_LENGTH);
  localparam logic [StageW-1:0] LenUser     = StageW'(USER_CODE_LENGTH);

  logic [StageW-1:0] entry_q, entry_d, entry_mid;
  logic [StageW-1:0] prog_q, prog_d;
  kcl_pkg::relock_e  relock_q, relock_d;
  logic              flag_q, flag_d;
  logic [7:0]        code_q [MaxLen];
  logic [7:0]        pend_q [USER_CODE_LENGTH];

  logic [StageW-1:0] len;
  logic [StageW-1:0] entry_pos;
  logic [StageW-1:0] prog_pos;
  logic              hit;
  logic              valid_key;
  logic              pend_we;
  logic              commit;

  assign len       = flag_q ? LenUser : LenFactory;
  assign entry_pos = entry_q - StageOne;
  assign prog_pos  = prog_q - StageOne;
  assign hit       = (key_char_i == code_q[entry_pos[IdxW-1:0]]);
  assign valid_key = ((key_char_i >= kcl_pkg::KeyZero) && (key_char_i <= kcl_pkg::KeyNine)) ||
                     ((key_char_i >= kcl_pkg::KeyA) && (key_char_i <= kcl_pkg::KeyD));

  // Entry machine, then relock, which may override the entry stage.
  always_comb begin
    entry_mid = entry_q;
    if (entry_q == '0) begin
      if (key_char_i == kcl_pkg::KeyHash) entry_mid = StageOne;
    end else if (entry_q >= StageOpen) begin
      entry_mid = StageOpen;
    end else if (hit) begin
      // Matching the digit at position len-1 or beyond opens the lock.
      entry_mid = (entry_q >= len) ? StageOpen : entry_q + StageOne;
    end else if (key_char_i == kcl_pkg::KeyHash) begin
      entry_mid = StageOne;
    end

    entry_d  = entry_mid;
    relock_d = relock_q;
    case (relock_q)
      kcl_pkg::RELOCK_START: relock_d = kcl_pkg::RELOCK_WAIT;
      kcl_pkg::RELOCK_WAIT: begin
        if (lock_button_i) begin
          entry_d  = '0;
          relock_d = kcl_pkg::RELOCK_FIRED;
        end
      end
      default: relock_d = kcl_pkg::RELOCK_WAIT;
    endcase
  end

  // Programming machine.
  always_comb begin
    prog_d  = prog_q;
    flag_d  = flag_q;
    pend_we = 1'b0;
    commit  = 1'b0;
    if (prog_q == '0) begin
      if ((key_char_i == kcl_pkg::KeyStar) && lock_button_i) prog_d = StageOne;
    end else if (prog_q >= StageCommit) begin
      commit = 1'b1;
      flag_d = 1'b1;
      prog_d = '0;
    end else if (valid_key) begin
      pend_we = 1'b1;
      prog_d  = prog_q + StageOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q  <= '0;
      prog_q   <= '0;
      relock_q <= kcl_pkg::RELOCK_START;
      flag_q   <= 1'b0;
      for (int i = 0; i < MaxLen; i++) begin
        code_q[i] <= kcl_pkg::KeyDigit1 + 8'(i);
      end
    end else if (step_i) begin
      entry_q  <= entry_d;
      prog_q   <= prog_d;
      relock_q <= relock_d;
      flag_q   <= flag_d;
      if (commit) begin
        for (int i = 0; i < USER_CODE_LENGTH; i++) begin
          code_q[i] <= pend_q[i];
        end
      end
    end
  end

  // Pending digits are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (step_i && pend_we) begin
      pend_q[prog_pos[PendIdxW-1:0]] <= key_char_i;
    end
  end

  assign result_o.unlocked       = (entry_d == StageOpen);
  assign result_o.entry_progress = entry_d[2:0];
  assign result_o.program_stage  = prog_d[2:0];
  assign result_o.code_changed   = flag_d;

endmodule

/* rtl/keypad_combination_lock_top.sv */
// Keypad combination lock: one tick beat in, one status beat out.
// Ports are stream style: s_axis carries the tick (key character and relock
// button level), m_axis carries the lock status after that tick.
// The state update happens on the edge that accepts the input beat, and the
// status lands in the output register on the same edge.
// Throughput is one beat per cycle unless the receiver stalls; the limit is the
// single pass through entry, relock and programming logic between state registers.
// The input is ready whenever the output register is empty or being drained,
// so a beat can enter while the previous status is taken in the same cycle.
// When the receiver stalls, the status holds in the output register and
// s_axis_tready_o drops until it is taken.
// Reset (rst_ni low, asynchronous) clears the output valid flag, returns all
// machines to idle and loads the factory code 1-2-3-4-5 (for the default
// lengths). No clearing pass is needed after reset.
// Depends on kcl_pkg and kcl_core.
module keypad_combination_lock_top #(
  parameter int FACTORY_CODE_LENGTH = 5,
  parameter int USER_CODE_LENGTH    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] key_char, [8] lock_button, [15:9] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [0] unlocked, [3:1] entry_progress,
                                       // [6:4] program_stage, [7] code_changed
);

  kcl_pkg::result_t result;
  kcl_pkg::result_t out_q;
  logic             out_valid_q;
  logic             accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  kcl_core #(
    .FACTORY_CODE_LENGTH(FACTORY_CODE_LENGTH),
    .USER_CODE_LENGTH   (USER_CODE_LENGTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .key_char_i   (s_axis_tdata_i[7:0]),
    .lock_button_i(s_axis_tdata_i[8]),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

/* test/keypad_combination_lock_top_tb.sv */
// Self-checking testbench for keypad_combination_lock_top: drives tick beats,
// predicts the lock status of each tick and checks every status beat.
// Depends on kcl_pkg and keypad_combination_lock_top.
`timescale 1ns / 100ps

module keypad_combination_lock_top_tb;

  localparam int FactoryLen   = 5;
  localparam int UserLen      = 4;
  localparam int MaxLen       = (FactoryLen > UserLen) ? FactoryLen : UserLen;
  localparam int OpenStage    = MaxLen + 1;
  localparam int CommitStage  = UserLen + 1;
  localparam int CycleLimit   = 300000;
  localparam int RandomTicks  = 160;
  localparam logic [7:0] KeyNone = 8'h00;

  logic        clk_i;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;

  keypad_combination_lock_top #(
    .FACTORY_CODE_LENGTH(FactoryLen),
    .USER_CODE_LENGTH   (UserLen)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // [7:0] key_char, [8] lock_button, [15:9] zero
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)    // [0] unlocked, [3:1] entry_progress,
                                // [6:4] program_stage, [7] code_changed
  );

  // Lock state as this testbench predicts it.
  int unsigned      entry_pos;
  kcl_pkg::relock_e relock_st;
  int unsigned      prog_pos;
  logic [7:0]       code_q [MaxLen];
  logic [7:0]       pending_q [UserLen];
  logic             user_code;

  kcl_pkg::result_t status_q [$];
  kcl_pkg::result_t seen_status;
  kcl_pkg::result_t want_status;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned tick_cnt       = 0;
  int unsigned checked_cnt    = 0;
  int unsigned open_cnt       = 0;
  int unsigned commit_cnt     = 0;
  int unsigned error_cnt      = 0;
  int unsigned cycle_cnt      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_code_key(logic [7:0] key);
    return (key >= kcl_pkg::KeyZero && key <= kcl_pkg::KeyNine) ||
           (key >= kcl_pkg::KeyA && key <= kcl_pkg::KeyD);
  endfunction

  function automatic logic [7:0] random_code_key();
    int unsigned n;
    n = $urandom_range(13);
    return (n < 10) ? kcl_pkg::KeyZero + 8'(n) : kcl_pkg::KeyA + 8'(n - 10);
  endfunction

  // Advances the predicted state by one tick: entry, then relock, then programming.
  function automatic kcl_pkg::result_t lock_status_after_tick(logic [7:0] key, logic btn);
    int unsigned      len;
    int unsigned      pos;
    kcl_pkg::result_t res;
    len = user_code ? UserLen : FactoryLen;
    if (entry_pos == 0) begin
      if (key == kcl_pkg::KeyHash) entry_pos = 1;
    end else if (entry_pos >= OpenStage) begin
      entry_pos = OpenStage;
    end else begin
      pos = entry_pos - 1;
      if (pos < MaxLen && key == code_q[pos]) begin
        entry_pos = (pos + 1 >= len) ? OpenStage : entry_pos + 1;
      end else if (key == kcl_pkg::KeyHash) begin
        entry_pos = 1;
      end
    end

    case (relock_st)
      kcl_pkg::RELOCK_START: relock_st = kcl_pkg::RELOCK_WAIT;
      kcl_pkg::RELOCK_WAIT: begin
        if (btn) begin
          entry_pos = 0;
          relock_st = kcl_pkg::RELOCK_FIRED;
        end
      end
      default: relock_st = kcl_pkg::RELOCK_WAIT;
    endcase

    if (prog_pos == 0) begin
      if (key == kcl_pkg::KeyStar && btn) prog_pos = 1;
    end else if (prog_pos >= CommitStage) begin
      for (int i = 0; i < UserLen; i++) code_q[i] = pending_q[i];
      user_code = 1'b1;
      prog_pos = 0;
      commit_cnt++;
    end else if (is_code_key(key)) begin
      pending_q[prog_pos - 1] = key;
      prog_pos++;
    end

    res.unlocked       = (entry_pos == OpenStage);
    res.entry_progress = 3'(entry_pos);
    res.program_stage  = 3'(prog_pos);
    res.code_changed   = user_code;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_tick(logic [7:0] key, logic btn);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {7'b0, btn, key};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    status_q.push_back(lock_status_after_tick(key, btn));
    if (status_q[$].unlocked) open_cnt++;
    tick_cnt++;
    @(negedge clk_i);
  endtask

  // Holds the sender off until every predicted status beat has come back.
  task automatic drain_status();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (status_q.size() != 0);
  endtask

  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_n && m_valid && m_ready) begin
      seen_status = kcl_pkg::result_t'(m_data);
      if (status_q.size() == 0) begin
        error_cnt++;
        $display("%0t: status beat %h with nothing expected", $time, m_data);
      end else begin
        want_status = status_q.pop_front();
        checked_cnt++;
        if (^m_data === 1'bx) begin
          error_cnt++;
          $display("%0t: status beat has unknown bits, expected %h, actual %h",
                   $time, want_status, m_data);
        end else begin
          check_field("unlocked", want_status.unlocked, seen_status.unlocked);
          check_field("entry_progress", want_status.entry_progress,
                      seen_status.entry_progress);
          check_field("program_stage", want_status.program_stage,
                      seen_status.program_stage);
          check_field("code_changed", want_status.code_changed, seen_status.code_changed);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("** keypad_combination_lock_top: FAILED **");
      $finish;
    end
  end

  // Keys outside the keypad set, every key bit high and low, button both ways.
  task automatic test_key_extremes();
    send_tick(8'hFF, 1'b1);
    send_tick(8'h80, 1'b0);
    send_tick(8'h7F, 1'b0);
  endtask

  // Factory code with a wrong digit, a repeated '#', a restart and the open hold.
  task automatic test_factory_unlock();
    send_tick(kcl_pkg::KeyHash, 1'b0);
    send_tick(kcl_pkg::KeyHash, 1'b0);
    send_tick(kcl_pkg::KeyDigit1, 1'b0);
    send_tick(kcl_pkg::KeyNine, 1'b0);
    send_tick(kcl_pkg::KeyHash, 1'b0);
    for (int i = 0; i < FactoryLen; i++) send_tick(kcl_pkg::KeyDigit1 + 8'(i), 1'b0);
    send_tick(KeyNone, 1'b0);
  endtask

  // A press relocks; the press on the following tick is ignored.
  task automatic test_relock();
    send_tick(KeyNone, 1'b1);
    send_tick(kcl_pkg::KeyHash, 1'b1);
  endtask

  // The digits typed for entry also fill the new code; the commit lands while
  // entry waits on the fifth position, which still holds the old digit.
  task automatic test_code_change_mid_entry();
    send_tick(kcl_pkg::KeyStar, 1'b1);
    send_tick(kcl_pkg::KeyHash, 1'b0);
    send_tick(8'h45, 1'b0);
    for (int i = 0; i < UserLen; i++) send_tick(kcl_pkg::KeyDigit1 + 8'(i), 1'b0);
    send_tick(KeyNone, 1'b0);
    send_tick(kcl_pkg::KeyDigit1 + 8'(UserLen), 1'b0);
    send_tick(kcl_pkg::KeyD, 1'b0);
  endtask

  task automatic try_current_code();
    int unsigned len;
    int unsigned bad;
    logic [7:0]  digit;
    len = user_code ? UserLen : FactoryLen;
    bad = ($urandom_range(99) < 20) ? $urandom_range(len - 1) : MaxLen;
    if ($urandom_range(1)) send_tick(KeyNone, 1'b0);
    send_tick(kcl_pkg::KeyHash, 1'b0);
    for (int i = 0; i < len; i++) begin
      digit = code_q[i];
      if (i == bad) digit = digit ^ 8'h01;
      send_tick(digit, 1'b0);
      if ($urandom_range(3) == 0) send_tick(KeyNone, 1'b0);
    end
    repeat ($urandom_range(2)) send_tick(KeyNone, 1'b0);
    if ($urandom_range(99) < 30) send_tick(KeyNone, 1'b1);
  endtask

  task automatic program_new_code();
    logic [7:0] junk;
    if ($urandom_range(99) < 80) send_tick(KeyNone, 1'b1);
    send_tick(kcl_pkg::KeyStar, 1'b1);
    for (int i = 0; i < UserLen; i++) begin
      if ($urandom_range(99) < 15) begin
        junk = 8'($urandom_range(255));
        send_tick(is_code_key(junk) ? KeyNone : junk, 1'($urandom_range(1)));
      end
      send_tick(random_code_key(), 1'b0);
    end
    send_tick(KeyNone, 1'b0);
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned stop_at;
    int unsigned pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = tick_cnt + RandomTicks;
    while (tick_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        try_current_code();
      end else if (pick < 65) begin
        program_new_code();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 3)) send_tick(KeyNone, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_tick(8'($urandom_range(255)), 1'($urandom_range(99) < 30));
      end
    end
    drain_status();
  endtask

  initial begin
    entry_pos = 0;
    relock_st = kcl_pkg::RELOCK_START;
    prog_pos  = 0;
    user_code = 1'b0;
    for (int i = 0; i < MaxLen; i++) code_q[i] = kcl_pkg::KeyDigit1 + 8'(i);
    for (int i = 0; i < UserLen; i++) pending_q[i] = KeyNone;

    repeat (7) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    test_key_extremes();
    test_factory_unlock();
    test_relock();
    test_code_change_mid_entry();
    drain_status();

    test_random_phase(0, 0);
    test_random_phase(71, 0);
    test_random_phase(0, 71);
    test_random_phase(29, 29);
    repeat (4) @(negedge clk_i);

    $display("Run covered %0d ticks and %0d checked status beats, with %0d open results",
             tick_cnt, checked_cnt, open_cnt);
    $display("and %0d code changes, under four sender and receiver stall mixes.", commit_cnt);
    if (error_cnt == 0 && status_q.size() == 0) begin
      $display("** keypad_combination_lock_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d status beats never arrived", error_cnt, status_q.size());
      $display("** keypad_combination_lock_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/kcl_pkg.sv
rtl/kcl_core.sv
rtl/keypad_combination_lock_top.sv
test/keypad_combination_lock_top_tb.sv
